// ===== rtl/frame_header_parser_top_macros.svh =====
// assertion macros for the frame header parser
`ifndef FRAME_HEADER_PARSER_TOP_MACROS_SVH
`define FRAME_HEADER_PARSER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define FHP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define FHP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/fhp_pkg.sv =====
// shared types, constants and helpers for the frame header parser
package fhp_pkg;

	localparam logic [7:0] MAGIC_FIRST_RST  = 8'h50;
	localparam logic [7:0] MAGIC_SECOND_RST = 8'h57;
	localparam logic [2:0] MAX_VARINT_BYTES = 3'd5;
	localparam int unsigned TDATA_W = 96;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_MAGIC = 2'd1,
		ST_NEED_MORE = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	typedef enum logic {
		REG_MAGIC_FIRST  = 1'b0,
		REG_MAGIC_SECOND = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		POS_MAGIC0 = 3'd0,
		POS_MAGIC1 = 3'd1,
		POS_VERSION = 3'd2,
		POS_FLAGS  = 3'd3,
		POS_OPCODE = 3'd4,
		POS_STREAM = 3'd5,
		POS_LENGTH = 3'd6
	} pos_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  version;
		logic [7:0]  flags_out;
		logic [7:0]  opcode_out;
		logic [31:0] flow_id;
		logic [31:0] payload_length;
		logic [3:0]  header_bytes;
	} res_t;

	// seven-bit group placed at its varint position, bits past 31 dropped
	function automatic logic [31:0] group_bits(input logic [7:0] b, input logic [2:0] cnt);
		logic [31:0] g;
		g = {25'd0, b[6:0]};
		case (cnt)
			3'd0: group_bits = g;
			3'd1: group_bits = g << 7;
			3'd2: group_bits = g << 14;
			3'd3: group_bits = g << 21;
			3'd4: group_bits = g << 28;
			default: group_bits = 32'd0;
		endcase
	endfunction

endpackage

// ===== rtl/fhp_core.sv =====
// header position state machine, varint accumulators and result formation
module fhp_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic [7:0]    data_byte,
	input  logic          last_available,
	input  logic [7:0]    magic_first,
	input  logic [7:0]    magic_second,
	output logic          res_hit,
	output fhp_pkg::res_t res
);
	import fhp_pkg::*;

	pos_t        pos_q, pos_d;
	logic [2:0]  shift_q, shift_d, shift_inc;
	logic        mis_q, mis_d;
	logic [7:0]  version_q, version_d;
	logic [7:0]  flags_q, flags_d;
	logic [7:0]  opcode_q, opcode_d;
	logic [31:0] stream_q, stream_d;
	logic [31:0] length_q, length_d;
	logic [3:0]  bytes_q, bytes_inc;
	status_t     res_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= POS_MAGIC0;
			shift_q   <= '0;
			mis_q     <= 1'b0;
			version_q <= '0;
			flags_q   <= '0;
			opcode_q  <= '0;
			stream_q  <= '0;
			length_q  <= '0;
			bytes_q   <= '0;
		end else if (step) begin
			if (res_hit) begin
				pos_q     <= POS_MAGIC0;
				shift_q   <= '0;
				mis_q     <= 1'b0;
				version_q <= '0;
				flags_q   <= '0;
				opcode_q  <= '0;
				stream_q  <= '0;
				length_q  <= '0;
				bytes_q   <= '0;
			end else begin
				pos_q     <= pos_d;
				shift_q   <= shift_d;
				mis_q     <= mis_d;
				version_q <= version_d;
				flags_q   <= flags_d;
				opcode_q  <= opcode_d;
				stream_q  <= stream_d;
				length_q  <= length_d;
				bytes_q   <= bytes_inc;
			end
		end
	end

	always_comb begin
		pos_d      = pos_q;
		shift_d    = shift_q;
		mis_d      = mis_q;
		version_d  = version_q;
		flags_d    = flags_q;
		opcode_d   = opcode_q;
		stream_d   = stream_q;
		length_d   = length_q;
		bytes_inc  = bytes_q + 4'd1;
		shift_inc  = shift_q + 3'd1;
		res_hit    = 1'b0;
		res_status = ST_OK;
		case (pos_q)
			POS_MAGIC0, POS_MAGIC1, POS_VERSION, POS_FLAGS: begin
				if (pos_q == POS_MAGIC0 && data_byte != magic_first) mis_d = 1'b1;
				if (pos_q == POS_MAGIC1 && data_byte != magic_second) mis_d = 1'b1;
				if (pos_q == POS_VERSION) version_d = data_byte;
				if (pos_q == POS_FLAGS) flags_d = data_byte;
				pos_d = pos_t'(pos_q + 3'd1);
				if (last_available) begin
					res_hit    = 1'b1;
					res_status = ST_NEED_MORE;
				end
			end
			POS_OPCODE: begin
				opcode_d = data_byte;
				if (mis_q) begin
					res_hit    = 1'b1;
					res_status = ST_BAD_MAGIC;
				end else begin
					pos_d = POS_STREAM;
					if (last_available) begin
						res_hit    = 1'b1;
						res_status = ST_NEED_MORE;
					end
				end
			end
			POS_STREAM: begin
				stream_d = stream_q | group_bits(data_byte, shift_q);
				shift_d  = shift_inc;
				if (!data_byte[7]) begin
					shift_d = '0;
					pos_d   = POS_LENGTH;
					if (last_available) begin
						res_hit    = 1'b1;
						res_status = ST_NEED_MORE;
					end
				end else if (shift_inc >= MAX_VARINT_BYTES) begin
					res_hit    = 1'b1;
					res_status = ST_OVERFLOW;
				end else if (last_available) begin
					res_hit    = 1'b1;
					res_status = ST_NEED_MORE;
				end
			end
			POS_LENGTH: begin
				length_d = length_q | group_bits(data_byte, shift_q);
				shift_d  = shift_inc;
				if (!data_byte[7]) begin
					res_hit    = 1'b1;
					res_status = ST_OK;
				end else if (shift_inc >= MAX_VARINT_BYTES) begin
					res_hit    = 1'b1;
					res_status = ST_OVERFLOW;
				end else if (last_available) begin
					res_hit    = 1'b1;
					res_status = ST_NEED_MORE;
				end
			end
			default: begin
				pos_d = POS_MAGIC0;
			end
		endcase
	end

	always_comb begin
		res        = '0;
		res.status = res_status;
		if (res_status == ST_OK) begin
			res.version        = version_d;
			res.flags_out      = flags_d;
			res.opcode_out     = opcode_d;
			res.flow_id        = stream_d;
			res.payload_length = length_d;
			res.header_bytes   = bytes_inc;
		end
	end

endmodule

// ===== rtl/frame_header_parser_top.sv =====
// frame header parser top level: input stage, parser core, result register, config
//
// bytes of a frame header enter on the s_ channel, one per request: s_tdata holds the
// byte and s_tlast says no further byte is in the buffer now. a result leaves on the
// m_ channel when a header completes, when the magic check fails on the fifth byte,
// when a varint runs past five bytes, or when the buffer ends early; m_tuser holds
// the status and m_tdata the parsed fields (zero for any status other than ok).
// the magic bytes are set through the cfg_ channel, index 0 first and 1 second;
// other indexes are ignored. cfg_ready is always high.
// one byte is taken per cycle while s_tready is high. a byte is registered in the
// input stage, and its result in the output register. while a result waits on
// m_tready, bytes that give no result keep flowing; the input stage holds only a
// byte whose result would need the busy output register, and s_tready then drops.
// reset clears the parse state, empties both stages and loads the magic registers
// with 0x50 and 0x57.
module frame_header_parser_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,  // data_byte
	input  logic                        s_tlast,  // last_available
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [fhp_pkg::TDATA_W-1:0] m_tdata,  // version, flags_out, opcode_out,
	                                              // flow_id, payload_length,
	                                              // header_bytes, zero fill
	output logic [1:0]                  m_tuser,  // status
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [7:0]                  cfg_data
);
	import fhp_pkg::*;

	`include "frame_header_parser_top_macros.svh"

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       advance;
	logic       hit;
	res_t       res;
	logic       out_valid_q;
	res_t       out_res_q;
	logic [7:0] magic_first_q;
	logic [7:0] magic_second_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_first_q  <= MAGIC_FIRST_RST;
			magic_second_q <= MAGIC_SECOND_RST;
		end else if (cfg_valid && cfg_ready && cfg_index[1] == 1'b0) begin
			case (reg_idx_t'(cfg_index[0]))
				REG_MAGIC_FIRST:  magic_first_q  <= cfg_data;
				REG_MAGIC_SECOND: magic_second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!hit || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	fhp_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.data_byte      (byte_s1),
		.last_available (last_s1),
		.magic_first    (magic_first_q),
		.magic_second   (magic_second_q),
		.res_hit        (hit),
		.res            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && hit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && hit) begin
			out_res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_res_q.status;
	assign m_tdata  = {4'd0,
	                   out_res_q.header_bytes,
	                   out_res_q.payload_length,
	                   out_res_q.flow_id,
	                   out_res_q.opcode_out,
	                   out_res_q.flags_out,
	                   out_res_q.version};

	`FHP_ASSERT_NOW(a_err_fields_zero, m_tvalid && m_tuser != ST_OK, m_tdata == '0, "non-ok result carries field data")
	`FHP_ASSERT_NOW(a_ok_min_len, m_tvalid && m_tuser == ST_OK, m_tdata[91:88] >= 4'd7, "ok result shorter than minimal header")
	`FHP_ASSERT_NEXT(a_s1_hold, valid_s1 && !advance, valid_s1 && $stable(byte_s1) && $stable(last_s1), "held input byte lost or changed")
	`FHP_ASSERT_NEXT(a_no_overwrite, out_valid_q && !m_tready, $stable(out_res_q), "waiting result overwritten")

endmodule

// ===== tb/tb_frame_header_parser_top.sv =====
// self-checking testbench for the frame header parser: directed table, random headers, config phases
`timescale 1ns / 100ps

module tb_frame_header_parser_top;
	import fhp_pkg::*;

	localparam int unsigned LIMIT = 400000;
	localparam int unsigned HOLD_CYCLES = 600;
	localparam int unsigned PHASE_ITEMS = 310;
	localparam int unsigned SETTLE = 4;

	localparam logic [1:0] IDX_FIRST  = {1'b0, REG_MAGIC_FIRST};
	localparam logic [1:0] IDX_SECOND = {1'b0, REG_MAGIC_SECOND};
	localparam logic [1:0] IDX_SPARE_A = 2'd2;
	localparam logic [1:0] IDX_SPARE_B = 2'd3;

	localparam res_t OK_ZERO7 = '{ST_OK, 8'h00, 8'h00, 8'h00, 32'h0, 32'h0, 4'd7};
	localparam res_t BAD_ZERO = '{ST_BAD_MAGIC, 8'h00, 8'h00, 8'h00, 32'h0, 32'h0, 4'd0};
	localparam res_t NEED_ZERO = '{ST_NEED_MORE, 8'h00, 8'h00, 8'h00, 32'h0, 32'h0, 4'd0};
	localparam res_t OVF_ZERO = '{ST_OVERFLOW, 8'h00, 8'h00, 8'h00, 32'h0, 32'h0, 4'd0};

	typedef struct {
		logic [7:0] b;
		logic       last;
		logic       typed;
		res_t       want;
	} row_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata = 8'h00;
	logic                s_tlast = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [TDATA_W-1:0]  m_tdata;
	logic [1:0]          m_tuser;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [1:0]          cfg_index = 2'd0;
	logic [7:0]          cfg_data = 8'h00;

	// side info travelling with the byte on the request
	logic                drv_typed = 1'b0;
	res_t                drv_want = '0;

	// parser shadow state
	logic [7:0]          mf = MAGIC_FIRST_RST;
	logic [7:0]          ms = MAGIC_SECOND_RST;
	pos_t                pos = POS_MAGIC0;
	logic [2:0]          vshift = 3'd0;
	logic                mism = 1'b0;
	logic [7:0]          ver_h = 8'h00;
	logic [7:0]          flg_h = 8'h00;
	logic [7:0]          opc_h = 8'h00;
	logic [31:0]         sid_acc = 32'h0;
	logic [31:0]         len_acc = 32'h0;
	logic [3:0]          nbytes = 4'd0;

	res_t                pending_results[$];
	row_t                plan[$];
	logic [8:0]          frame_q[$];
	int unsigned         error_count = 0;
	int unsigned         cycle_count = 0;
	int unsigned         items_sent = 0;
	int                  send_burst = 0;
	int                  recv_burst = 0;
	logic                random_on = 1'b0;
	logic                hold_on = 1'b0;

	frame_header_parser_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	task automatic flag_error(input string what, input logic [31:0] got, input logic [31:0] want);
		if (error_count < 100)
			$display("mismatch %s: got 0x%0h want 0x%0h (cycle %0d)", what, got, want, cycle_count);
		error_count++;
	endtask

	function automatic int pick_wait(inout int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			burst = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 9);
	endfunction

	task automatic wrap_up(input status_t st, output res_t r);
		r = '0;
		r.status = st;
		if (st == ST_OK) begin
			r.version = ver_h;
			r.flags_out = flg_h;
			r.opcode_out = opc_h;
			r.flow_id = sid_acc;
			r.payload_length = len_acc;
			r.header_bytes = nbytes;
		end
		pos = POS_MAGIC0;
		vshift = 3'd0;
		mism = 1'b0;
		ver_h = 8'h00;
		flg_h = 8'h00;
		opc_h = 8'h00;
		sid_acc = 32'h0;
		len_acc = 32'h0;
		nbytes = 4'd0;
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic last, output logic fired,
			output res_t r);
		logic [63:0] wide;
		logic [31:0] grp;
		logic        settled;
		fired = 1'b0;
		r = '0;
		settled = 1'b0;
		wide = {57'd0, b[6:0]} << (7 * vshift);
		grp = wide[31:0];
		nbytes = nbytes + 4'd1;
		case (pos)
			POS_MAGIC0: begin
				if (b != mf) mism = 1'b1;
			end
			POS_MAGIC1: begin
				if (b != ms) mism = 1'b1;
			end
			POS_VERSION: ver_h = b;
			POS_FLAGS: flg_h = b;
			POS_OPCODE: begin
				opc_h = b;
				if (mism) begin
					wrap_up(ST_BAD_MAGIC, r);
					fired = 1'b1;
					settled = 1'b1;
				end
			end
			POS_STREAM: begin
				sid_acc = sid_acc | grp;
				vshift = vshift + 3'd1;
				settled = 1'b1;
				if (!b[7]) begin
					vshift = 3'd0;
					pos = POS_LENGTH;
					if (last) begin
						wrap_up(ST_NEED_MORE, r);
						fired = 1'b1;
					end
				end else if (vshift >= MAX_VARINT_BYTES) begin
					wrap_up(ST_OVERFLOW, r);
					fired = 1'b1;
				end else if (last) begin
					wrap_up(ST_NEED_MORE, r);
					fired = 1'b1;
				end
			end
			default: begin
				len_acc = len_acc | grp;
				vshift = vshift + 3'd1;
				settled = 1'b1;
				if (!b[7]) begin
					wrap_up(ST_OK, r);
					fired = 1'b1;
				end else if (vshift >= MAX_VARINT_BYTES) begin
					wrap_up(ST_OVERFLOW, r);
					fired = 1'b1;
				end else if (last) begin
					wrap_up(ST_NEED_MORE, r);
					fired = 1'b1;
				end
			end
		endcase
		if (!settled) begin
			pos = pos_t'(pos + 3'd1);
			if (last) begin
				wrap_up(ST_NEED_MORE, r);
				fired = 1'b1;
			end
		end
	endtask

	always @(posedge clk) begin : watch
		res_t w;
		res_t r;
		logic fired;
		cycle_count <= cycle_count + 1;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					flag_error("unexpected result, status", m_tuser, 32'h0);
				end else begin
					w = pending_results.pop_front();
					if (m_tuser !== w.status) flag_error("status", m_tuser, w.status);
					if (m_tdata[7:0] !== w.version) flag_error("version", m_tdata[7:0], w.version);
					if (m_tdata[15:8] !== w.flags_out)
						flag_error("flags_out", m_tdata[15:8], w.flags_out);
					if (m_tdata[23:16] !== w.opcode_out)
						flag_error("opcode_out", m_tdata[23:16], w.opcode_out);
					if (m_tdata[55:24] !== w.flow_id)
						flag_error("flow_id", m_tdata[55:24], w.flow_id);
					if (m_tdata[87:56] !== w.payload_length)
						flag_error("payload_length", m_tdata[87:56], w.payload_length);
					if (m_tdata[91:88] !== w.header_bytes)
						flag_error("header_bytes", m_tdata[91:88], w.header_bytes);
					if (m_tdata[TDATA_W-1:92] !== '0)
						flag_error("zero fill", m_tdata[TDATA_W-1:92], 32'h0);
				end
			end
			if (s_tvalid && s_tready) begin
				parse_byte(s_tdata, s_tlast, fired, r);
				if (fired || drv_typed)
					pending_results.push_back(drv_typed ? drv_want : r);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
			input res_t want);
		int gap;
		gap = pick_wait(send_burst);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		drv_typed <= typed;
		drv_want <= want;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
	endtask

	task automatic add_row(input logic [7:0] b, input logic last, input logic typed,
			input res_t want);
		row_t row;
		row.b = b;
		row.last = last;
		row.typed = typed;
		row.want = want;
		plan.push_back(row);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == IDX_FIRST)
			mf = val;
		else if (idx == IDX_SECOND)
			ms = val;
		@(posedge clk);
	endtask

	// drain everything in flight so the block sits idle
	task automatic quiesce();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic push_varint(input int n, input logic runaway);
		logic [6:0] g;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 5))
				0: g = 7'h00;
				1: g = 7'h7f;
				default: g = 7'($urandom_range(0, 127));
			endcase
			frame_q.push_back({1'b0, (i < n - 1) || runaway, g});
		end
	endtask

	task automatic gen_header();
		int kind;
		int cut;
		int n;
		logic [7:0] flip;
		frame_q.delete();
		kind = $urandom_range(0, 99);
		if (kind >= 93) begin
			// noise, closed by a last byte so the next header starts clean
			n = $urandom_range(1, 12);
			for (int i = 0; i < n; i++)
				frame_q.push_back({$urandom_range(0, 3) == 0, 8'($urandom_range(0, 255))});
			frame_q[frame_q.size() - 1][8] = 1'b1;
		end else begin
			frame_q.push_back({1'b0, mf});
			frame_q.push_back({1'b0, ms});
			for (int i = 0; i < 3; i++)
				frame_q.push_back({1'b0, 8'($urandom_range(0, 255))});
			if (kind >= 70 && kind < 78) begin
				flip = 8'($urandom_range(1, 255));
				case ($urandom_range(0, 2))
					0: frame_q[0][7:0] = frame_q[0][7:0] ^ flip;
					1: frame_q[1][7:0] = frame_q[1][7:0] ^ flip;
					default: begin
						frame_q[0][7:0] = frame_q[0][7:0] ^ flip;
						frame_q[1][7:0] = frame_q[1][7:0] ^ 8'($urandom_range(1, 255));
					end
				endcase
				frame_q[4][8] = 1'($urandom_range(0, 1));
			end else if (kind >= 86) begin
				if ($urandom_range(0, 1) == 0) begin
					push_varint(5, 1'b1);
				end else begin
					push_varint($urandom_range(1, 5), 1'b0);
					push_varint(5, 1'b1);
				end
				frame_q[frame_q.size() - 1][8] = 1'($urandom_range(0, 1));
			end else begin
				push_varint($urandom_range(1, 5), 1'b0);
				push_varint($urandom_range(1, 5), 1'b0);
				if (kind >= 78) begin
					cut = $urandom_range(1, frame_q.size() - 1);
					while (frame_q.size() > cut) void'(frame_q.pop_back());
					frame_q[frame_q.size() - 1][8] = 1'b1;
				end else begin
					frame_q[frame_q.size() - 1][8] = 1'($urandom_range(0, 1));
				end
			end
		end
		foreach (frame_q[i])
			send_byte(frame_q[i][7:0], frame_q[i][8], 1'b0, '0);
	endtask

	initial begin : drain
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = pick_wait(recv_burst);
			if (stall > 0 || hold_on) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
				while (hold_on) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	// long receiver hold-off so the input side backs up
	initial begin : backpressure
		wait (random_on === 1'b1);
		repeat ($urandom_range(20, 200)) @(posedge clk);
		hold_on <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_on <= 1'b0;
	end

	initial begin : watchdog
		while (cycle_count < LIMIT) @(posedge clk);
		$display("tb_frame_header_parser_top: errors");
		$finish;
	end

	initial begin : stimulus
		int unsigned target;
		logic [7:0] m0;
		logic [7:0] m1;

		// all-zero header, completing byte marked last
		add_row(MAGIC_FIRST_RST, 1'b0, 1'b0, '0);
		add_row(MAGIC_SECOND_RST, 1'b0, 1'b0, '0);
		add_row(8'h00, 1'b0, 1'b0, '0);
		add_row(8'h00, 1'b0, 1'b0, '0);
		add_row(8'h00, 1'b0, 1'b0, '0);
		add_row(8'h00, 1'b0, 1'b0, '0);
		add_row(8'h00, 1'b1, 1'b1, OK_ZERO7);
		// bad first magic reported on the fifth byte despite last
		add_row(8'h00, 1'b0, 1'b0, '0);
		add_row(MAGIC_SECOND_RST, 1'b0, 1'b0, '0);
		add_row(8'hff, 1'b0, 1'b0, '0);
		add_row(8'hff, 1'b0, 1'b0, '0);
		add_row(8'hff, 1'b1, 1'b1, BAD_ZERO);
		// short buffer on the very first byte
		add_row(MAGIC_FIRST_RST, 1'b1, 1'b1, NEED_ZERO);
		// stream id without terminator, overflow beats need-more
		add_row(MAGIC_FIRST_RST, 1'b0, 1'b0, '0);
		add_row(MAGIC_SECOND_RST, 1'b0, 1'b0, '0);
		add_row(8'h80, 1'b0, 1'b0, '0);
		add_row(8'h7f, 1'b0, 1'b0, '0);
		add_row(8'h01, 1'b0, 1'b0, '0);
		add_row(8'hff, 1'b0, 1'b0, '0);
		add_row(8'hff, 1'b0, 1'b0, '0);
		add_row(8'hff, 1'b0, 1'b0, '0);
		add_row(8'hff, 1'b0, 1'b0, '0);
		add_row(8'hff, 1'b1, 1'b1, OVF_ZERO);

		wait (arst_n === 1'b1);
		@(posedge clk);
		foreach (plan[i])
			send_byte(plan[i].b, plan[i].last, plan[i].typed, plan[i].want);
		quiesce();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin m0 = 8'h00; m1 = 8'hff; end
				1: begin m0 = 8'hff; m1 = 8'h00; end
				3: begin m0 = 8'hff; m1 = 8'hff; end
				default: begin
					m0 = 8'($urandom_range(0, 255));
					m1 = 8'($urandom_range(0, 255));
				end
			endcase
			cfg_write(IDX_FIRST, m0);
			cfg_write(IDX_SECOND, m1);
			cfg_write((ph % 2 == 0) ? IDX_SPARE_A : IDX_SPARE_B, 8'($urandom_range(0, 255)));
			if (ph == 0) random_on <= 1'b1;
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) gen_header();
			quiesce();
		end

		if (error_count == 0 && pending_results.size() == 0)
			$display("tb_frame_header_parser_top: clean");
		else
			$display("tb_frame_header_parser_top: errors");
		$finish;
	end

endmodule
